/* hdl/lcdnw_pkg.sv */
// Package for the character LCD 4-bit write sequencer: microcode word layout,
// sequencer states, hold-time codes and the microprogram table.
// No dependencies.
package lcdnw_pkg;

    localparam int PC_W     = 6;
    localparam int HOLD_W   = 16;
    localparam int TDATA_W  = 24;

    localparam logic [1:0] CMD_COMMAND = 2'd0;
    localparam logic [1:0] CMD_DATA    = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;

    localparam logic [PC_W-1:0] ENTRY_BYTE = 6'd0;
    localparam logic [PC_W-1:0] ENTRY_INIT = 6'd6;

    localparam logic [7:0] BYTE_CLEAR = 8'h01;
    localparam logic [7:0] BYTE_HOME  = 8'h02;

    typedef enum logic [1:0] {
        NIB_HI,
        NIB_LO,
        NIB_CONST
    } nib_sel_t;

    typedef enum logic [2:0] {
        HOLD_SETUP,
        HOLD_SETTLE,
        HOLD_SETTLE_CMD,
        HOLD_WAKE_LONG,
        HOLD_WAKE_SHORT,
        HOLD_POWERUP,
        HOLD_CLEAR
    } hold_sel_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        nib_sel_t  nib_sel;
        logic [3:0] nib_const;
        logic      en;
        hold_sel_t hold_sel;
        logic      last;
    } uword_t;

    // Sequencer to datapath: one event per issue.
    typedef struct packed {
        logic       issue;
        uword_t     word;
        logic       rs;
        logic [7:0] byte_val;
    } ctrl_t;

    function automatic uword_t uw(nib_sel_t s, logic [3:0] c, logic e, hold_sel_t h,
                                  logic l);
        uword_t w;
        w.nib_sel   = s;
        w.nib_const = c;
        w.en        = e;
        w.hold_sel  = h;
        w.last      = l;
        return w;
    endfunction

    function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            // byte routine: high nibble, then low nibble
            6'd0:  w = uw(NIB_HI,    4'h0, 1'b0, HOLD_SETUP,      1'b0);
            6'd1:  w = uw(NIB_HI,    4'h0, 1'b1, HOLD_SETUP,      1'b0);
            6'd2:  w = uw(NIB_HI,    4'h0, 1'b0, HOLD_SETTLE,     1'b0);
            6'd3:  w = uw(NIB_LO,    4'h0, 1'b0, HOLD_SETUP,      1'b0);
            6'd4:  w = uw(NIB_LO,    4'h0, 1'b1, HOLD_SETUP,      1'b0);
            6'd5:  w = uw(NIB_LO,    4'h0, 1'b0, HOLD_SETTLE_CMD, 1'b1);
            // power-on init
            6'd6:  w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_POWERUP,    1'b0);
            6'd7:  w = uw(NIB_CONST, 4'h3, 1'b0, HOLD_SETUP,      1'b0);
            6'd8:  w = uw(NIB_CONST, 4'h3, 1'b1, HOLD_SETUP,      1'b0);
            6'd9:  w = uw(NIB_CONST, 4'h3, 1'b0, HOLD_WAKE_LONG,  1'b0);
            6'd10: w = uw(NIB_CONST, 4'h3, 1'b0, HOLD_SETUP,      1'b0);
            6'd11: w = uw(NIB_CONST, 4'h3, 1'b1, HOLD_SETUP,      1'b0);
            6'd12: w = uw(NIB_CONST, 4'h3, 1'b0, HOLD_WAKE_LONG,  1'b0);
            6'd13: w = uw(NIB_CONST, 4'h3, 1'b0, HOLD_SETUP,      1'b0);
            6'd14: w = uw(NIB_CONST, 4'h3, 1'b1, HOLD_SETUP,      1'b0);
            6'd15: w = uw(NIB_CONST, 4'h3, 1'b0, HOLD_WAKE_SHORT, 1'b0);
            6'd16: w = uw(NIB_CONST, 4'h2, 1'b0, HOLD_SETUP,      1'b0);
            6'd17: w = uw(NIB_CONST, 4'h2, 1'b1, HOLD_SETUP,      1'b0);
            6'd18: w = uw(NIB_CONST, 4'h2, 1'b0, HOLD_SETTLE,     1'b0);
            // function set 0x28
            6'd19: w = uw(NIB_CONST, 4'h2, 1'b0, HOLD_SETUP,      1'b0);
            6'd20: w = uw(NIB_CONST, 4'h2, 1'b1, HOLD_SETUP,      1'b0);
            6'd21: w = uw(NIB_CONST, 4'h2, 1'b0, HOLD_SETTLE,     1'b0);
            6'd22: w = uw(NIB_CONST, 4'h8, 1'b0, HOLD_SETUP,      1'b0);
            6'd23: w = uw(NIB_CONST, 4'h8, 1'b1, HOLD_SETUP,      1'b0);
            6'd24: w = uw(NIB_CONST, 4'h8, 1'b0, HOLD_SETTLE,     1'b0);
            // display on 0x0C
            6'd25: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETUP,      1'b0);
            6'd26: w = uw(NIB_CONST, 4'h0, 1'b1, HOLD_SETUP,      1'b0);
            6'd27: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETTLE,     1'b0);
            6'd28: w = uw(NIB_CONST, 4'hC, 1'b0, HOLD_SETUP,      1'b0);
            6'd29: w = uw(NIB_CONST, 4'hC, 1'b1, HOLD_SETUP,      1'b0);
            6'd30: w = uw(NIB_CONST, 4'hC, 1'b0, HOLD_SETTLE,     1'b0);
            // clear 0x01
            6'd31: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETUP,      1'b0);
            6'd32: w = uw(NIB_CONST, 4'h0, 1'b1, HOLD_SETUP,      1'b0);
            6'd33: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETTLE,     1'b0);
            6'd34: w = uw(NIB_CONST, 4'h1, 1'b0, HOLD_SETUP,      1'b0);
            6'd35: w = uw(NIB_CONST, 4'h1, 1'b1, HOLD_SETUP,      1'b0);
            6'd36: w = uw(NIB_CONST, 4'h1, 1'b0, HOLD_CLEAR,      1'b0);
            // entry mode 0x06
            6'd37: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETUP,      1'b0);
            6'd38: w = uw(NIB_CONST, 4'h0, 1'b1, HOLD_SETUP,      1'b0);
            6'd39: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETTLE,     1'b0);
            6'd40: w = uw(NIB_CONST, 4'h6, 1'b0, HOLD_SETUP,      1'b0);
            6'd41: w = uw(NIB_CONST, 4'h6, 1'b1, HOLD_SETUP,      1'b0);
            6'd42: w = uw(NIB_CONST, 4'h6, 1'b0, HOLD_SETTLE,     1'b1);
            default: w = uw(NIB_CONST, 4'h0, 1'b0, HOLD_SETUP,    1'b1);
        endcase
        return w;
    endfunction

endpackage

/* hdl/char_lcd_nibble_write_sequencer.sv */
// Character LCD 4-bit bus write sequencer, top level.
// Depends on lcdnw_pkg, lcdnw_sequencer and lcdnw_datapath.
//
// Usage:
//   Input items arrive on s_axis: tuser selects the request (0 command byte,
//   1 data byte, 2 power-on init; 3 is dropped without output), tdata holds
//   the byte. Each request becomes a run of pin events on m_axis, one item
//   per event, with tlast on the final event of the run.
//   A byte request gives 6 events, the init request 37. A microcode step
//   counter walks a ROM program, one event per cycle while the output
//   register drains. After an item is accepted the sequencer enters its
//   run state and issues the first event into the output register, which
//   drives m_axis.
//   s_axis_tready is high only between requests; the last event of one run
//   may still wait in the output register while the next item is taken.
//   If m_axis_tready is low the event is held and the step counter stops.
//   Reset clears the sequencer to idle and empties the output register.
module char_lcd_nibble_write_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] reg_select, [1] read_write, [2] enable_pin, [6:3] data_nibble,
    // [22:7] hold_us, [23] zero
    output logic [lcdnw_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast   // last
);
    import lcdnw_pkg::*;

    ctrl_t ctrl;
    logic  dp_ready;

    lcdnw_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_cmd   (s_axis_tuser),
        .req_byte  (s_axis_tdata),
        .dp_ready  (dp_ready),
        .ctrl      (ctrl)
    );

    lcdnw_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .dp_ready      (dp_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hdl/lcdnw_sequencer.sv */
// Microcode sequencer: step counter, dispatch on the request kind, ROM fetch.
// Depends on lcdnw_pkg.
module lcdnw_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           req_cmd,
    input  logic [7:0]           req_byte,
    input  logic                 dp_ready,
    output lcdnw_pkg::ctrl_t     ctrl
);
    import lcdnw_pkg::*;

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [7:0]      byte_reg, byte_next;
    logic            rs_reg, rs_next;
    uword_t          word;

    assign word = ucode_rom(pc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pc_reg   <= pc_next;
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
    end

    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        byte_next     = byte_reg;
        rs_next       = rs_reg;
        req_ready     = 1'b0;
        ctrl.issue    = 1'b0;
        ctrl.word     = word;
        ctrl.rs       = rs_reg;
        ctrl.byte_val = byte_reg;
        case (state_reg)
            SEQ_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    byte_next = req_byte;
                    rs_next   = (req_cmd == CMD_DATA);
                    // unused selector: drop the item
                    if (req_cmd == CMD_COMMAND || req_cmd == CMD_DATA) begin
                        pc_next    = ENTRY_BYTE;
                        state_next = SEQ_RUN;
                    end else if (req_cmd == CMD_INIT) begin
                        pc_next    = ENTRY_INIT;
                        state_next = SEQ_RUN;
                    end
                end
            end
            SEQ_RUN: begin
                ctrl.issue = dp_ready;
                if (dp_ready) begin
                    if (word.last) begin
                        state_next = SEQ_IDLE;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

/* hdl/lcdnw_datapath.sv */
// Event datapath: nibble select, hold-time decode and the output register.
// Depends on lcdnw_pkg.
module lcdnw_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lcdnw_pkg::ctrl_t          ctrl,
    output logic                      dp_ready,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [lcdnw_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    import lcdnw_pkg::*;

    logic                valid_reg, valid_next;
    logic [TDATA_W-1:0]  data_reg, data_next;
    logic                last_reg, last_next;
    logic [3:0]          nib;
    logic [HOLD_W-1:0]   hold;
    logic                long_cmd;

    assign long_cmd = !ctrl.rs &&
                      (ctrl.byte_val == BYTE_CLEAR || ctrl.byte_val == BYTE_HOME);

    always_comb begin
        case (ctrl.word.nib_sel)
            NIB_HI:  nib = ctrl.byte_val[7:4];
            NIB_LO:  nib = ctrl.byte_val[3:0];
            default: nib = ctrl.word.nib_const;
        endcase
        case (ctrl.word.hold_sel)
            HOLD_SETUP:      hold = 16'd1;
            HOLD_SETTLE:     hold = 16'd100;
            HOLD_SETTLE_CMD: hold = long_cmd ? 16'd2100 : 16'd100;
            HOLD_WAKE_LONG:  hold = 16'd4600;
            HOLD_WAKE_SHORT: hold = 16'd250;
            HOLD_POWERUP:    hold = 16'd50000;
            HOLD_CLEAR:      hold = 16'd2100;
            default:         hold = 16'd1;
        endcase
    end

    assign dp_ready = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (ctrl.issue) begin
            valid_next = 1'b1;
            data_next  = {1'b0, hold, nib, ctrl.word.en, 1'b0, ctrl.rs};
            last_next  = ctrl.word.last;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

/* hdl/lcdnw_checker.sv */
// Port-level checks for the LCD write sequencer, bound to the top level.
// Depends on lcdnw_pkg and char_lcd_nibble_write_sequencer.
module lcdnw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lcdnw_pkg::TDATA_W-1:0] m_axis_tdata
);
    import lcdnw_pkg::*;

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // every event is a write with a nonzero hold
    a_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[1] == 1'b0 && m_axis_tdata[22:7] != 16'd0))
        else $error("bad read_write or zero hold");

    // enable pulse is always the short hold
    a_pulse_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[22:7] == 16'd1))
        else $error("enable high with long hold");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled event changed");

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_checker u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
